>>> rtl/core/sah_pkg.sv
package sah_pkg;

    // Shared long divider: widest dividend is count * 1000 (42 bits),
    // widest divisor is 2 * duration (33 bits).
    localparam int DIV_NUM_W = 42;
    localparam int DIV_DEN_W = 33;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_TEXT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DURATION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CHARS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VARIETY  = 2'd3;

    localparam logic [7:0]  RST_NORMAL_TEXT  = 8'd0;
    localparam logic [31:0] RST_MIN_DURATION = 32'd1000;
    localparam logic [15:0] RST_MIN_CHARS    = 16'd30;
    localparam logic [15:0] RST_MIN_VARIETY  = 16'd15;

    localparam logic [1:0] OP_NEW_FILE = 2'd0;
    localparam logic [1:0] OP_RECORD   = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FILTERED = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [DIV_NUM_W-1:0] SPEED_SCALE = 42'd120000;
    localparam logic [DIV_NUM_W-1:0] READ_SCALE  = 42'd1000;

    typedef enum logic [1:0] {
        DIV_SPEED = 2'd0,
        DIV_ACC   = 2'd1,
        DIV_READ  = 2'd2
    } div_src_t;

    typedef struct packed {
        logic     take;
        logic     load_in;
        logic     clr_step;
        logic     clear_win;
        logic     win_upd;
        logic     div_start;
        div_src_t div_src;
        logic     rd_speed_q;
        logic     rd_acc_q;
        logic     rd_idx;
        logic     wr_speed;
        logic     wr_acc;
        logic     set_filt;
        logic     set_range;
        logic     norm_load;
        logic     out_load;
    } sah_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       pass;
        logic       dur_zero;
        logic       idx_bad;
        logic       div_busy;
        logic       q_spd_ok;
        logic       q_acc_ok;
        logic       acc_go;
        logic       peak_zero;
        logic       clr_last;
        logic       out_free;
    } sah_stat_t;

endpackage

>>> rtl/core/sah_divider.sv
module sah_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sah_pkg::DIV_NUM_W-1:0] num,
    input  logic [sah_pkg::DIV_DEN_W-1:0] den,
    output logic                          busy,
    output logic [sah_pkg::DIV_NUM_W-1:0] quot
);
    import sah_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 ge;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_DEN_W:0]   diff;

    // Restoring division, one quotient bit per cycle; quotient shifts into num_reg.
    always_comb
    begin
        trial    = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge       = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

>>> rtl/core/sah_ctrl.sv
module sah_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sah_pkg::sah_stat_t stat,
    output sah_pkg::sah_cmd_t  cmd
);
    import sah_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_DISP    = 13'b0000000000100,
        S_SPD_DIV = 13'b0000000001000,
        S_SPD_CHK = 13'b0000000010000,
        S_SPD_WR  = 13'b0000000100000,
        S_ACC_GO  = 13'b0000001000000,
        S_ACC_DIV = 13'b0000010000000,
        S_ACC_CHK = 13'b0000100000000,
        S_ACC_WR  = 13'b0001000000000,
        S_RD_DATA = 13'b0010000000000,
        S_RD_DIV  = 13'b0100000000000,
        S_FINISH  = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.div_src = DIV_SPEED;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.opcode)
                    OP_NEW_FILE:
                    begin
                        cmd.clear_win = 1'b1;
                        state_next    = S_FINISH;
                    end
                    OP_RECORD:
                    begin
                        if (!stat.pass)
                        begin
                            cmd.set_filt = 1'b1;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.win_upd = 1'b1;
                            if (stat.dur_zero)
                            begin
                                state_next = S_ACC_GO;
                            end
                            else
                            begin
                                cmd.div_start = 1'b1;
                                cmd.div_src   = DIV_SPEED;
                                state_next    = S_SPD_DIV;
                            end
                        end
                    end
                    OP_READ:
                    begin
                        if (stat.idx_bad)
                        begin
                            cmd.set_range = 1'b1;
                            state_next    = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_idx = 1'b1;
                            state_next = S_RD_DATA;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SPD_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_SPD_CHK;
                end
            end
            S_SPD_CHK:
            begin
                if (stat.q_spd_ok)
                begin
                    cmd.rd_speed_q = 1'b1;
                    state_next     = S_SPD_WR;
                end
                else
                begin
                    state_next = S_ACC_GO;
                end
            end
            S_SPD_WR:
            begin
                cmd.wr_speed = 1'b1;
                state_next   = S_ACC_GO;
            end
            S_ACC_GO:
            begin
                if (stat.acc_go)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_ACC;
                    state_next    = S_ACC_DIV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_ACC_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_ACC_CHK;
                end
            end
            S_ACC_CHK:
            begin
                if (stat.q_acc_ok)
                begin
                    cmd.rd_acc_q = 1'b1;
                    state_next   = S_ACC_WR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_ACC_WR:
            begin
                cmd.wr_acc = 1'b1;
                state_next = S_FINISH;
            end
            S_RD_DATA:
            begin
                if (stat.peak_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_READ;
                    state_next    = S_RD_DIV;
                end
            end
            S_RD_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.norm_load = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/sah_datapath.sv
module sah_datapath #(
    parameter int SPEED_BINS    = 751,
    parameter int ACCURACY_BINS = 1001,
    parameter int WINDOW_LEN    = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sah_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sah_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]                      opcode,
    input  logic                            record_ok,
    input  logic [7:0]                      text_kind,
    input  logic [31:0]                     duration_ms,
    input  logic [15:0]                     char_count,
    input  logic [15:0]                     error_count,
    input  logic [15:0]                     key_variety,
    input  logic                            which_histogram,
    input  logic [9:0]                      bin_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [9:0]                      speed_bin,
    output logic [9:0]                      accuracy_bin,
    output logic [9:0]                      normalized_count,
    input  sah_pkg::sah_cmd_t               cmd,
    output sah_pkg::sah_stat_t              stat
);
    import sah_pkg::*;

    localparam int SB_AW    = $clog2(SPEED_BINS);
    localparam int AB_AW    = $clog2(ACCURACY_BINS);
    localparam int MAX_BINS = (SPEED_BINS > ACCURACY_BINS) ? SPEED_BINS : ACCURACY_BINS;
    localparam int CLR_W    = $clog2(MAX_BINS);
    localparam int HEAD_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W    = 16 + $clog2(WINDOW_LEN + 1);
    localparam logic [DIV_NUM_W-1:0] ACC_SCALE = DIV_NUM_W'(2 * (ACCURACY_BINS - 1));

    // configuration
    logic [7:0]  normal_text_reg;
    logic [31:0] min_dur_reg;
    logic [15:0] min_chars_reg;
    logic [15:0] min_var_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_text_reg <= RST_NORMAL_TEXT;
            min_dur_reg     <= RST_MIN_DURATION;
            min_chars_reg   <= RST_MIN_CHARS;
            min_var_reg     <= RST_MIN_VARIETY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NORMAL_TEXT:  normal_text_reg <= cfg_data[7:0];
                CFG_MIN_DURATION: min_dur_reg     <= cfg_data[31:0];
                CFG_MIN_CHARS:    min_chars_reg   <= cfg_data[15:0];
                CFG_MIN_VARIETY:  min_var_reg     <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // latched item
    logic [1:0]  op_reg;
    logic        ok_reg;
    logic [7:0]  kind_reg;
    logic [31:0] dur_reg;
    logic [15:0] chars_reg;
    logic [15:0] errs_reg;
    logic [15:0] var_reg;
    logic        which_reg;
    logic [9:0]  idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= opcode;
            ok_reg    <= record_ok;
            kind_reg  <= text_kind;
            dur_reg   <= duration_ms;
            chars_reg <= char_count;
            errs_reg  <= error_count;
            var_reg   <= key_variety;
            which_reg <= which_histogram;
            idx_reg   <= bin_index;
        end
    end

    // window
    logic [15:0]       win_chars_reg [WINDOW_LEN];
    logic [15:0]       win_errs_reg  [WINDOW_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [SUM_W-1:0]  sum_c_reg;
    logic [SUM_W-1:0]  sum_e_reg;

    logic              win_full;
    logic [FILL_W:0]   pos_raw;
    logic [FILL_W:0]   pos_wrap;
    logic [HEAD_W-1:0] slot;
    logic [SUM_W-1:0]  old_c;
    logic [SUM_W-1:0]  old_e;

    always_comb
    begin
        win_full = fill_reg == FILL_W'(WINDOW_LEN);
        pos_raw  = (FILL_W + 1)'(head_reg) + (FILL_W + 1)'(fill_reg);
        pos_wrap = (pos_raw >= (FILL_W + 1)'(WINDOW_LEN)) ?
                   pos_raw - (FILL_W + 1)'(WINDOW_LEN) : pos_raw;
        slot     = win_full ? head_reg : pos_wrap[HEAD_W-1:0];
        old_c    = win_full ? SUM_W'(win_chars_reg[slot]) : '0;
        old_e    = win_full ? SUM_W'(win_errs_reg[slot]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            head_reg  <= '0;
            sum_c_reg <= '0;
            sum_e_reg <= '0;
        end
        else if (cmd.clear_win)
        begin
            fill_reg  <= '0;
            head_reg  <= '0;
            sum_c_reg <= '0;
            sum_e_reg <= '0;
        end
        else if (cmd.win_upd)
        begin
            sum_c_reg <= sum_c_reg - old_c + SUM_W'(chars_reg);
            sum_e_reg <= sum_e_reg - old_e + SUM_W'(errs_reg);
            if (win_full)
            begin
                head_reg <= (head_reg == HEAD_W'(WINDOW_LEN - 1)) ? '0 : head_reg + 1'b1;
            end
            else
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_upd)
        begin
            win_chars_reg[slot] <= chars_reg;
            win_errs_reg[slot]  <= errs_reg;
        end
    end

    // divider
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] quot;
    logic [SUM_W-1:0]     sum_diff;
    logic [31:0]          rd_cnt;
    logic [31:0]          rd_peak;
    logic [31:0]          spd_rdata;
    logic [31:0]          acc_rdata;
    logic [31:0]          spd_peak_reg;
    logic [31:0]          acc_peak_reg;

    always_comb
    begin
        sum_diff = sum_c_reg - sum_e_reg;
        rd_cnt   = which_reg ? acc_rdata : spd_rdata;
        rd_peak  = which_reg ? acc_peak_reg : spd_peak_reg;
        case (cmd.div_src)
            DIV_SPEED:
            begin
                div_num = DIV_NUM_W'(chars_reg) * SPEED_SCALE + DIV_NUM_W'(dur_reg);
                div_den = {dur_reg, 1'b0};
            end
            DIV_ACC:
            begin
                div_num = DIV_NUM_W'(sum_diff) * ACC_SCALE + DIV_NUM_W'(sum_c_reg);
                div_den = DIV_DEN_W'({sum_c_reg, 1'b0});
            end
            DIV_READ:
            begin
                div_num = DIV_NUM_W'(rd_cnt) * READ_SCALE;
                div_den = DIV_DEN_W'(rd_peak);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    sah_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (quot)
    );

    // histogram memories with clearing sweep
    logic [CLR_W-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    logic [31:0]      spd_mem [SPEED_BINS];
    logic [31:0]      acc_mem [ACCURACY_BINS];
    logic             spd_we;
    logic             acc_we;
    logic             spd_re;
    logic             acc_re;
    logic [SB_AW-1:0] spd_waddr;
    logic [SB_AW-1:0] spd_raddr;
    logic [AB_AW-1:0] acc_waddr;
    logic [AB_AW-1:0] acc_raddr;
    logic [31:0]      spd_inc;
    logic [31:0]      acc_inc;
    logic [31:0]      spd_wdata;
    logic [31:0]      acc_wdata;

    always_comb
    begin
        spd_inc   = (spd_rdata == '1) ? spd_rdata : spd_rdata + 32'd1;
        acc_inc   = (acc_rdata == '1) ? acc_rdata : acc_rdata + 32'd1;
        spd_we    = (cmd.clr_step && (32'(clr_reg) < 32'(SPEED_BINS))) || cmd.wr_speed;
        acc_we    = (cmd.clr_step && (32'(clr_reg) < 32'(ACCURACY_BINS))) || cmd.wr_acc;
        spd_waddr = cmd.clr_step ? clr_reg[SB_AW-1:0] : quot[SB_AW-1:0];
        acc_waddr = cmd.clr_step ? clr_reg[AB_AW-1:0] : quot[AB_AW-1:0];
        spd_wdata = cmd.clr_step ? '0 : spd_inc;
        acc_wdata = cmd.clr_step ? '0 : acc_inc;
        spd_re    = cmd.rd_speed_q || (cmd.rd_idx && !which_reg);
        acc_re    = cmd.rd_acc_q || (cmd.rd_idx && which_reg);
        spd_raddr = cmd.rd_idx ? SB_AW'(idx_reg) : quot[SB_AW-1:0];
        acc_raddr = cmd.rd_idx ? AB_AW'(idx_reg) : quot[AB_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (spd_we)
        begin
            spd_mem[spd_waddr] <= spd_wdata;
        end
        if (spd_re)
        begin
            spd_rdata <= spd_mem[spd_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (acc_re)
        begin
            acc_rdata <= acc_mem[acc_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_peak_reg <= '0;
            acc_peak_reg <= '0;
        end
        else
        begin
            if (cmd.wr_speed && (spd_inc > spd_peak_reg))
            begin
                spd_peak_reg <= spd_inc;
            end
            if (cmd.wr_acc && (acc_inc > acc_peak_reg))
            begin
                acc_peak_reg <= acc_inc;
            end
        end
    end

    // result build-up and output register
    logic [1:0] res_status_reg;
    logic [9:0] res_sbin_reg;
    logic [9:0] res_abin_reg;
    logic [9:0] res_norm_reg;
    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic [9:0] speed_bin_reg;
    logic [9:0] accuracy_bin_reg;
    logic [9:0] norm_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            res_status_reg <= ST_DONE;
            res_sbin_reg   <= '0;
            res_abin_reg   <= '0;
            res_norm_reg   <= '0;
        end
        else
        begin
            if (cmd.set_filt)
            begin
                res_status_reg <= ST_FILTERED;
            end
            if (cmd.set_range)
            begin
                res_status_reg <= ST_RANGE;
            end
            if (cmd.wr_speed)
            begin
                res_sbin_reg <= quot[9:0];
            end
            if (cmd.wr_acc)
            begin
                res_abin_reg <= quot[9:0];
            end
            if (cmd.norm_load)
            begin
                res_norm_reg <= quot[9:0];
            end
        end
        if (cmd.out_load)
        begin
            status_reg       <= res_status_reg;
            speed_bin_reg    <= res_sbin_reg;
            accuracy_bin_reg <= res_abin_reg;
            norm_reg         <= res_norm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign speed_bin        = speed_bin_reg;
    assign accuracy_bin     = accuracy_bin_reg;
    assign normalized_count = norm_reg;

    always_comb
    begin
        stat.opcode    = op_reg;
        stat.pass      = ok_reg && (kind_reg == normal_text_reg) && (dur_reg >= min_dur_reg) &&
                         (chars_reg >= min_chars_reg) && (var_reg >= min_var_reg) &&
                         (chars_reg > errs_reg);
        stat.dur_zero  = dur_reg == '0;
        stat.idx_bad   = which_reg ? (32'(idx_reg) >= 32'(ACCURACY_BINS)) :
                                     (32'(idx_reg) >= 32'(SPEED_BINS));
        stat.div_busy  = div_busy;
        stat.q_spd_ok  = (quot != '0) && (quot < DIV_NUM_W'(SPEED_BINS));
        stat.q_acc_ok  = (quot != '0) && (quot < DIV_NUM_W'(ACCURACY_BINS));
        stat.acc_go    = win_full && (sum_c_reg != '0) && (sum_c_reg >= sum_e_reg);
        stat.peak_zero = rd_peak == '0;
        stat.clr_last  = clr_reg == CLR_W'(MAX_BINS - 1);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

endmodule

>>> rtl/core/speed_accuracy_histogram_core.sv
// Speed and accuracy histogram core. Takes one item at a time on the input
// channel (opcode 0 new file, 1 record session, 2 read bin) and returns one
// result item for each. Accepted records are binned by rounded speed
// (chars*60000/ms) and, once the WINDOW_LEN-record window is full, by rounded
// window accuracy scaled to ACCURACY_BINS-1; counts saturate. Reads return
// floor(count*1000/peak). After reset a clearing sweep over addresses 0 to
// max(SPEED_BINS, ACCURACY_BINS)-1 zeroes both count memories; in_stall
// stays high during it, config writes are still taken. All items share one
// 42-bit restoring divider: a record uses up to two divisions plus memory
// read-modify-write, a read at most one division, a new-file or unused
// opcode none. One item is in flight at a time; a finished result waits in
// the output register while the next item is taken.
module speed_accuracy_histogram_core #(
    parameter int SPEED_BINS    = 751,
    parameter int ACCURACY_BINS = 1001,
    parameter int WINDOW_LEN    = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sah_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sah_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic                            record_ok,
    input  logic [7:0]                      text_kind,
    input  logic [31:0]                     duration_ms,
    input  logic [15:0]                     char_count,
    input  logic [15:0]                     error_count,
    input  logic [15:0]                     key_variety,
    input  logic                            which_histogram,
    input  logic [9:0]                      bin_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [9:0]                      speed_bin,
    output logic [9:0]                      accuracy_bin,
    output logic [9:0]                      normalized_count
);
    import sah_pkg::*;

    sah_cmd_t  cmd;
    sah_stat_t stat;

    // controller sequences each item; datapath holds config, window, memories
    sah_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    sah_datapath #(
        .SPEED_BINS    (SPEED_BINS),
        .ACCURACY_BINS (ACCURACY_BINS),
        .WINDOW_LEN    (WINDOW_LEN)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .opcode           (opcode),
        .record_ok        (record_ok),
        .text_kind        (text_kind),
        .duration_ms      (duration_ms),
        .char_count       (char_count),
        .error_count      (error_count),
        .key_variety      (key_variety),
        .which_histogram  (which_histogram),
        .bin_index        (bin_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .speed_bin        (speed_bin),
        .accuracy_bin     (accuracy_bin),
        .normalized_count (normalized_count),
        .cmd              (cmd),
        .stat             (stat)
    );

    // ready only in idle
    assign in_stall = !cmd.take;

    // divider is never restarted mid-division
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider restarted while busy");

    // after an item is taken the block is busy with it
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item taken while one is in flight");

    // a result never overwrites one still held by the consumer
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("output register overwritten while stalled");

endmodule

>>> dv/speed_accuracy_histogram_core_test.sv
module speed_accuracy_histogram_core_test;
    import sah_pkg::*;

    localparam int SPEED_BINS    = 751;
    localparam int ACCURACY_BINS = 1001;
    localparam int WINDOW_LEN    = 10;
    // Watchdog on the whole run: records, stalls, gaps and the clearing sweep
    // after reset are well inside this bound.
    localparam int CYCLE_LIMIT   = 900000;
    localparam int RANDOM_ITEMS  = 1300;

    // One session or command as driven on the input channel.
    typedef struct {
        logic [1:0]  op;
        logic        ok;
        logic [7:0]  kind;
        logic [31:0] dur;
        logic [15:0] chars;
        logic [15:0] errs;
        logic [15:0] variety;
        logic        which;
        logic [9:0]  idx;
    } session_t;

    // One result item.
    typedef struct {
        logic [1:0] st;
        logic [9:0] sbin;
        logic [9:0] abin;
        logic [9:0] norm;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic        record_ok;
    logic [7:0]  text_kind;
    logic [31:0] duration_ms;
    logic [15:0] char_count;
    logic [15:0] error_count;
    logic [15:0] key_variety;
    logic        which_histogram;
    logic [9:0]  bin_index;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [9:0]  speed_bin;
    logic [9:0]  accuracy_bin;
    logic [9:0]  normalized_count;

    speed_accuracy_histogram_core #(
        .SPEED_BINS   (SPEED_BINS),
        .ACCURACY_BINS(ACCURACY_BINS),
        .WINDOW_LEN   (WINDOW_LEN)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .record_ok       (record_ok),
        .text_kind       (text_kind),
        .duration_ms     (duration_ms),
        .char_count      (char_count),
        .error_count     (error_count),
        .key_variety     (key_variety),
        .which_histogram (which_histogram),
        .bin_index       (bin_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .speed_bin       (speed_bin),
        .accuracy_bin    (accuracy_bin),
        .normalized_count(normalized_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the histogram state and the filter registers
    // ---------------------------------------------------------------
    logic [7:0]  want_kind;
    logic [31:0] floor_dur;
    logic [15:0] floor_chars;
    logic [15:0] floor_variety;

    logic [31:0] speed_tally [SPEED_BINS];
    logic [31:0] acc_tally [ACCURACY_BINS];
    logic [31:0] speed_top;
    logic [31:0] acc_top;
    logic [15:0] win_chars [WINDOW_LEN];
    logic [15:0] win_errs [WINDOW_LEN];
    int unsigned win_count;
    int unsigned win_oldest;
    logic [19:0] chars_total;
    logic [19:0] errs_total;

    outcome_t    pending_outcomes[$];
    int          mismatches;
    int unsigned cycles;

    // Handshake pacing knobs read by the sender (steady) and the stall process.
    bit          steady;
    int          holdoff_reqs;
    int          holdoff_done;
    int          holdoff_left;

    // Count bump with saturation; the running peak follows the bin.
    function automatic void bump_bin(ref logic [31:0] bin, ref logic [31:0] peak);
        if (bin != 32'hFFFF_FFFF)
            bin = bin + 1;
        if (bin > peak)
            peak = bin;
    endfunction

    // Apply one accepted item to the shadow state and give its result.
    function automatic outcome_t bin_session(session_t s);
        outcome_t         r;
        longint unsigned  spd;
        longint unsigned  acc;
        longint unsigned  cnt;
        longint unsigned  pk;
        int unsigned      slot;
        r = '{st: ST_DONE, sbin: '0, abin: '0, norm: '0};
        if (s.op == OP_NEW_FILE) begin
            win_count   = 0;
            win_oldest  = 0;
            chars_total = '0;
            errs_total  = '0;
        end
        else if (s.op == OP_RECORD) begin
            if (!s.ok || s.kind != want_kind || s.dur < floor_dur ||
                s.chars < floor_chars || s.variety < floor_variety ||
                s.chars <= s.errs) begin
                r.st = ST_FILTERED;
            end
            else begin
                // zero duration only passes with a zero floor: no speed bin
                if (s.dur != 0) begin
                    spd = (longint'(s.chars) * 120000 + s.dur) / (longint'(s.dur) * 2);
                    if (spd > 0 && spd < SPEED_BINS) begin
                        r.sbin = spd[9:0];
                        bump_bin(speed_tally[spd], speed_top);
                    end
                end
                if (win_count >= WINDOW_LEN) begin
                    slot        = win_oldest;
                    chars_total = chars_total - win_chars[slot];
                    errs_total  = errs_total - win_errs[slot];
                    win_oldest  = (slot + 1) % WINDOW_LEN;
                end
                else begin
                    slot      = (win_oldest + win_count) % WINDOW_LEN;
                    win_count = win_count + 1;
                end
                win_chars[slot] = s.chars;
                win_errs[slot]  = s.errs;
                chars_total     = chars_total + s.chars;
                errs_total      = errs_total + s.errs;
                if (win_count >= WINDOW_LEN && chars_total != 0 &&
                    chars_total >= errs_total) begin
                    acc = (2 * longint'(chars_total - errs_total) * (ACCURACY_BINS - 1)
                           + chars_total) / (2 * longint'(chars_total));
                    if (acc > 0 && acc < ACCURACY_BINS) begin
                        r.abin = acc[9:0];
                        bump_bin(acc_tally[acc], acc_top);
                    end
                end
            end
        end
        else if (s.op == OP_READ) begin
            if (s.idx >= (s.which ? ACCURACY_BINS : SPEED_BINS)) begin
                r.st = ST_RANGE;
            end
            else begin
                cnt = s.which ? acc_tally[s.idx] : speed_tally[s.idx];
                pk  = s.which ? acc_top : speed_top;
                if (pk != 0)
                    r.norm = 10'((cnt * 1000) / pk);
            end
        end
        // unused opcode: all-zero done result
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Offer one item, with an occasional gap in front; it is binned in
    // the shadow model at the edge where the block takes it.
    task automatic send_session(session_t s);
        bit taken;
        if (!steady && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= s.op;
        record_ok       <= s.ok;
        text_kind       <= s.kind;
        duration_ms     <= s.dur;
        char_count      <= s.chars;
        error_count     <= s.errs;
        key_variety     <= s.variety;
        which_histogram <= s.which;
        bin_index       <= s.idx;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        pending_outcomes.push_back(bin_session(s));
    endtask

    // Let every outstanding result drain so that registers may change.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write enable stays high across back-to-back writes; the caller drops it.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_NORMAL_TEXT:  want_kind     = value[7:0];
            CFG_MIN_DURATION: floor_dur     = value;
            CFG_MIN_CHARS:    floor_chars   = value[15:0];
            CFG_MIN_VARIETY:  floor_variety = value[15:0];
            default:          ;
        endcase
    endtask

    task automatic set_filters(logic [7:0] kind, logic [31:0] dur,
                               logic [15:0] chars, logic [15:0] variety);
        wait_idle();
        write_reg(CFG_NORMAL_TEXT, 32'(kind));
        write_reg(CFG_MIN_DURATION, dur);
        write_reg(CFG_MIN_CHARS, 32'(chars));
        write_reg(CFG_MIN_VARIETY, 32'(variety));
        cfg_we <= 1'b0;
    endtask

    function automatic session_t make_record(logic [31:0] dur, logic [15:0] chars,
                                             logic [15:0] errs, logic [15:0] variety);
        session_t s;
        s = '{op: OP_RECORD, ok: 1'b1, kind: want_kind, dur: dur, chars: chars,
              errs: errs, variety: variety, which: 1'b0, idx: '0};
        return s;
    endfunction

    function automatic session_t make_read(logic which, logic [9:0] idx);
        session_t s;
        s = '{op: OP_READ, ok: 1'b0, kind: '0, dur: '0, chars: '0, errs: '0,
              variety: '0, which: which, idx: idx};
        return s;
    endfunction

    function automatic session_t make_plain(logic [1:0] op);
        session_t s;
        s = '{op: op, ok: 1'b0, kind: '0, dur: '0, chars: '0, errs: '0,
              variety: '0, which: 1'b0, idx: '0};
        return s;
    endfunction

    // A session that passes every filter, with a speed mostly in range and
    // an error rate mostly low so the accuracy bins spread out.
    function automatic session_t make_good_session();
        longint unsigned lo;
        longint unsigned d;
        logic [15:0]     c;
        logic [15:0]     e;
        logic [15:0]     v;
        lo = (floor_chars == 0) ? 1 : floor_chars;
        if ($urandom_range(9) == 0)
            c = 16'($urandom_range(65535, lo));
        else
            c = 16'($urandom_range((lo > 3000) ? 65535 : 3000, lo));
        if ($urandom_range(3) == 0)
            e = 16'($urandom_range(c - 1, 0));
        else
            e = 16'($urandom_range((c / 10 > 0) ? c / 10 : 0, 0));
        v = 16'($urandom_range(65535, floor_variety));
        d = (longint'(c) * 60000) / $urandom_range(800, 1);
        if ($urandom_range(15) == 0)
            d = $urandom;
        if (d < floor_dur)
            d = floor_dur + $urandom_range(100, 0);
        if (d > 64'hFFFF_FFFF)
            d = 64'hFFFF_FFFF;
        return make_record(32'(d), c, e, v);
    endfunction

    function automatic session_t make_noise();
        session_t s;
        s = '{op: 2'($urandom_range(3)), ok: 1'($urandom), kind: 8'($urandom),
              dur: $urandom, chars: 16'($urandom), errs: 16'($urandom),
              variety: 16'($urandom), which: 1'($urandom), idx: 10'($urandom)};
        return s;
    endfunction

    // Random mix: mostly well-formed sessions, plus reads, file breaks,
    // the unused opcode and fully random items.
    task automatic run_mix(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_session(make_good_session());
            else if (pick < 72)
                send_session(make_read(1'($urandom), 10'($urandom)));
            else if (pick < 77)
                send_session(make_plain(OP_NEW_FILE));
            else if (pick < 79)
                send_session(make_plain(2'd3));
            else
                send_session(make_noise());
        end
    endtask

    // ---------------------------------------------------------------
    // Named tests
    // ---------------------------------------------------------------

    task automatic test_empty_reads();
        send_session(make_read(1'b0, 10'd0));
        send_session(make_read(1'b1, 10'd500));
        send_session(make_read(1'b0, 10'd751));
        send_session(make_read(1'b1, 10'd1023));
    endtask

    task automatic test_filters();
        session_t s;
        s = make_record(32'd5000, 16'd100, 16'd2, 16'd20);
        s.ok = 1'b0;
        send_session(s);
        s = make_record(32'd5000, 16'd100, 16'd2, 16'd20);
        s.kind = 8'd7;
        send_session(s);
        send_session(make_record(32'd999, 16'd100, 16'd2, 16'd20));
        send_session(make_record(32'd5000, 16'd29, 16'd2, 16'd20));
        send_session(make_record(32'd5000, 16'd100, 16'd2, 16'd14));
        send_session(make_record(32'd5000, 16'd100, 16'd100, 16'd20));
    endtask

    // Fill the window past its length; speed bins cover the low end, the
    // upper edge, an overflow and the widest duration.
    task automatic test_window_fill();
        send_session(make_record(32'd1000, 16'd30, 16'd0, 16'd15));
        send_session(make_record(32'd80, 16'd1, 16'd0, 16'd15));
        send_session(make_record(32'd2400, 16'd30, 16'd29, 16'd15));
        send_session(make_record(32'd8000, 16'd100, 16'd0, 16'd65535));
        send_session(make_record(32'hFFFF_FFFF, 16'd65535, 16'd65534, 16'd65535));
        for (int n = 0; n < 8; n++)
            send_session(make_record(32'(6000 + n * 700), 16'(200 + n), 16'(n), 16'd40));
        send_session(make_read(1'b0, 10'd750));
        send_session(make_read(1'b1, 10'd1000));
        send_session(make_read(1'b1, 10'd1001));
        send_session(make_plain(2'd3));
        send_session(make_plain(OP_NEW_FILE));
        send_session(make_record(32'd3000, 16'd90, 16'd1, 16'd30));
    endtask

    task automatic test_zero_duration();
        set_filters(8'hFF, 32'd0, 16'd0, 16'd0);
        send_session(make_record(32'd0, 16'd45, 16'd3, 16'd0));
        send_session(make_record(32'd0, 16'd1, 16'd0, 16'd0));
        send_session(make_read(1'b0, 10'd0));
    endtask

    // Receiver holds off while items keep coming, so the block backs up.
    task automatic test_backpressure();
        holdoff_reqs = holdoff_reqs + 1;
        run_mix(20);
    endtask

    task automatic test_random_settings();
        steady = 1'b1;
        set_filters(RST_NORMAL_TEXT, RST_MIN_DURATION, RST_MIN_CHARS, RST_MIN_VARIETY);
        run_mix(200);
        steady = 1'b0;
        run_mix(450);
        set_filters(8'hA5, 32'd0, 16'd1, 16'd0);
        run_mix(300);
        set_filters(8'h5A, 32'hFFFF_FFFF, 16'd65535, 16'd65535);
        run_mix(40);
        set_filters(8'd0, 32'd20000, 16'd500, 16'd1000);
        run_mix(RANDOM_ITEMS - 990);
    endtask

    // ---------------------------------------------------------------
    // Result checking and output pacing
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        outcome_t w;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $error("result item with nothing expected");
                mismatches++;
            end
            else begin
                w = pending_outcomes.pop_front();
                if (status !== w.st) begin
                    $error("status exp %0d got %0d", w.st, status);
                    mismatches++;
                end
                if (speed_bin !== w.sbin) begin
                    $error("speed_bin exp %0d got %0d", w.sbin, speed_bin);
                    mismatches++;
                end
                if (accuracy_bin !== w.abin) begin
                    $error("accuracy_bin exp %0d got %0d", w.abin, accuracy_bin);
                    mismatches++;
                end
                if (normalized_count !== w.norm) begin
                    $error("normalized_count exp %0d got %0d", w.norm, normalized_count);
                    mismatches++;
                end
            end
        end
    end

    // Random output stalls, none while steady, and a long hold-off on request.
    always @(posedge clk)
    begin
        if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            out_stall    <= 1'b1;
        end
        else if (holdoff_done != holdoff_reqs) begin
            holdoff_done <= holdoff_reqs;
            holdoff_left <= 400;
            out_stall    <= 1'b1;
        end
        else begin
            out_stall <= !steady && ($urandom_range(99) < 22);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        out_stall       = 1'b0;
        opcode          = '0;
        record_ok       = 1'b0;
        text_kind       = '0;
        duration_ms     = '0;
        char_count      = '0;
        error_count     = '0;
        key_variety     = '0;
        which_histogram = 1'b0;
        bin_index       = '0;
        mismatches      = 0;
        cycles          = 0;
        steady          = 1'b0;
        holdoff_reqs    = 0;
        holdoff_done    = 0;
        holdoff_left    = 0;
        want_kind       = RST_NORMAL_TEXT;
        floor_dur       = RST_MIN_DURATION;
        floor_chars     = RST_MIN_CHARS;
        floor_variety   = RST_MIN_VARIETY;
        foreach (speed_tally[i]) speed_tally[i] = '0;
        foreach (acc_tally[i]) acc_tally[i] = '0;
        speed_top   = '0;
        acc_top     = '0;
        win_count   = 0;
        win_oldest  = 0;
        chars_total = '0;
        errs_total  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_filters();
        test_window_fill();
        test_zero_duration();
        test_backpressure();
        test_random_settings();

        wait_idle();
        repeat (150) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/sah_pkg.sv
rtl/core/sah_divider.sv
rtl/core/sah_ctrl.sv
rtl/core/sah_datapath.sv
rtl/core/speed_accuracy_histogram_core.sv
dv/speed_accuracy_histogram_core_test.sv
